FILE: src/fsp_pkg.sv
// ----------------------------------------------------------------------------
// fsp_pkg
// Shared types, codes and constants of the FASTA record parser.
// ----------------------------------------------------------------------------
package fsp_pkg;

  // Comment buffer geometry
  localparam int COMMENT_LEN = 32;
  localparam int CADDR_W     = $clog2(COMMENT_LEN);
  localparam int FILL_W      = $clog2(COMMENT_LEN + 1);

  localparam int BYTE_W      = 8;
  localparam int CNT_W       = 24;
  localparam int TALLY_W     = CNT_W + 1;
  localparam int OUT_DATA_W  = 64;

  localparam logic [CNT_W-1:0]  MAX_BASES_RST = {CNT_W{1'b1}};
  localparam logic [BYTE_W-1:0] CHAR_GT       = 8'h3E;
  localparam logic [BYTE_W-1:0] CHAR_LF       = 8'h0A;

  typedef enum logic [2:0] {
    ST_SEEK,
    ST_HEADER,
    ST_LINE_START,
    ST_BODY,
    ST_EMIT,
    ST_BASE
  } parse_state_e;

  typedef enum logic [1:0] {
    KIND_COMMENT = 2'd0,
    KIND_BASE    = 2'd1,
    KIND_END     = 2'd2
  } result_kind_e;

  // One write and one read request to the comment buffer
  typedef struct packed {
    logic               we;
    logic [CADDR_W-1:0] waddr;
    logic [BYTE_W-1:0]  wdata;
    logic               re;
    logic [CADDR_W-1:0] raddr;
  } cbuf_req_t;

  function automatic logic is_letter(input logic [BYTE_W-1:0] c);
    is_letter = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

endpackage

FILE: src/fsp_comment_ram.sv
// ----------------------------------------------------------------------------
// fsp_comment_ram
// Comment byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fsp_comment_ram (
  input  logic                      clk_i,
  input  fsp_pkg::cbuf_req_t        req_i,
  output logic [fsp_pkg::BYTE_W-1:0] rdata_o
);
  import fsp_pkg::*;

  logic [BYTE_W-1:0] mem_q [COMMENT_LEN];
  logic [BYTE_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/fasta_record_parser.sv
// ----------------------------------------------------------------------------
// fasta_record_parser
// Splits a FASTA byte stream into comment, base and record-end results.
// ----------------------------------------------------------------------------
// Input stream: one file byte per request in s_axis_tdata_i, s_axis_tuser_i
// high marks end of file (byte ignored). Output stream: one result per
// request, kind in m_axis_tuser_o, tlast on the final result of an input.
// max_bases is written through cfg_we_i / cfg_wdata_i; the user must do so only
// while the block idles, and the block itself does not enforce this.
//
// Throughput, while the output register can take a result: one input byte per
// cycle in headers and bodies. At the first body line the buffered comment
// (up to 32 bytes) is read out of the comment RAM one byte per cycle, paced
// by its single read port; input stalls meanwhile and, if the first body byte
// is a kept base, while it follows the comment. Any other base or record end is
// valid in the cycle after its input is taken; comment bytes pass the RAM first.
//
// Reset puts the parser in the seek state with counters cleared and
// max_bases at its largest value; the comment RAM is not cleared. When the
// receiver stalls, the output register holds its result and input is taken
// only once that register can accept the next one.
module fasta_record_parser (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // config
  input  logic                                cfg_we_i,
  input  logic [fsp_pkg::CNT_W-1:0]           cfg_wdata_i,   // max_bases
  // input stream
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [fsp_pkg::BYTE_W-1:0]          s_axis_tdata_i, // [7:0] in_byte
  input  logic                                s_axis_tuser_i, // [0] end_of_file
  // output stream
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [7:0] value, [31:8] record_index, [55:32] length, [56] truncated
  output logic [fsp_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o,
  output logic [1:0]                          m_axis_tuser_o, // [1:0] kind
  output logic                                m_axis_tlast_o  // last_of_run
);
  import fsp_pkg::*;

  parse_state_e      state_q, state_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [TALLY_W-1:0] tally_q, tally_d;
  logic [CNT_W-1:0]  rec_cnt_q, rec_cnt_d;
  logic [CNT_W-1:0]  max_bases_q;
  logic [BYTE_W-1:0] pend_byte_q, pend_byte_d;
  logic              pend_base_q, pend_base_d;
  logic [FILL_W-1:0] emit_idx_q, emit_idx_d;

  logic              out_valid_q, out_valid_d;
  result_kind_e      out_kind_q, out_kind_d;
  logic [BYTE_W-1:0] out_value_q, out_value_d;
  logic [CNT_W-1:0]  out_idx_q, out_idx_d;
  logic [CNT_W-1:0]  out_len_q, out_len_d;
  logic              out_trunc_q, out_trunc_d;
  logic              out_last_q, out_last_d;

  cbuf_req_t         cbuf_req;
  logic [BYTE_W-1:0] cbuf_rdata;

  logic              load_ok, take, load, eof, letter, keep, more;
  logic [BYTE_W-1:0] c;
  logic [CNT_W-1:0]  tally_inc;

  assign c       = s_axis_tdata_i;
  assign eof     = s_axis_tuser_i;
  assign letter  = is_letter(c);
  assign load_ok = !out_valid_q || m_axis_tready_i;
  assign keep    = tally_q[CNT_W-1:0] < max_bases_q;
  assign tally_inc = tally_q[CNT_W-1:0] + CNT_W'(1);
  assign more    = (emit_idx_q + FILL_W'(1)) < fill_q;

  // Input is taken in the parsing states whenever the output slot is free
  always_comb begin
    case (state_q)
      ST_SEEK, ST_HEADER, ST_LINE_START, ST_BODY: s_axis_tready_o = load_ok;
      default:                                     s_axis_tready_o = 1'b0;
    endcase
  end
  assign take = s_axis_tvalid_i && s_axis_tready_o;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_SEEK: begin
        if (take && !eof && (c == CHAR_GT)) state_d = ST_HEADER;
      end
      ST_HEADER: begin
        if (take) begin
          if (eof)                 state_d = ST_SEEK;
          else if (c == CHAR_LF)   state_d = ST_LINE_START;
        end
      end
      ST_LINE_START: begin
        if (take) begin
          if (eof)                 state_d = ST_SEEK;
          else if (c == CHAR_GT)   state_d = ST_HEADER;
          else                     state_d = ST_EMIT;
        end
      end
      ST_BODY: begin
        if (take) begin
          if (eof)                 state_d = ST_SEEK;
          else if (c == CHAR_GT)   state_d = ST_HEADER;
        end
      end
      ST_EMIT: begin
        if (load_ok && !more) state_d = pend_base_q ? ST_BASE : ST_BODY;
      end
      ST_BASE: begin
        if (load_ok) state_d = ST_BODY;
      end
      default: state_d = ST_SEEK;
    endcase
  end

  // Datapath, buffer requests and result formation
  always_comb begin
    fill_d      = fill_q;
    tally_d     = tally_q;
    rec_cnt_d   = rec_cnt_q;
    pend_byte_d = pend_byte_q;
    pend_base_d = pend_base_q;
    emit_idx_d  = emit_idx_q;
    cbuf_req    = '0;
    load        = 1'b0;
    out_kind_d  = out_kind_q;
    out_value_d = out_value_q;
    out_idx_d   = out_idx_q;
    out_len_d   = out_len_q;
    out_trunc_d = out_trunc_q;
    out_last_d  = out_last_q;

    case (state_q)
      ST_SEEK: begin
        if (take && !eof && (c == CHAR_GT)) begin
          rec_cnt_d      = rec_cnt_q + CNT_W'(1);
          cbuf_req.we    = 1'b1;
          cbuf_req.waddr = '0;
          cbuf_req.wdata = CHAR_GT;
          fill_d         = FILL_W'(1);
        end
      end
      ST_HEADER: begin
        // append header byte while room is left
        if (take && !eof && (c != CHAR_LF) && (fill_q < FILL_W'(COMMENT_LEN))) begin
          cbuf_req.we    = 1'b1;
          cbuf_req.waddr = fill_q[CADDR_W-1:0];
          cbuf_req.wdata = c;
          fill_d         = fill_q + FILL_W'(1);
        end
      end
      ST_LINE_START: begin
        if (take && !eof) begin
          if (c == CHAR_GT) begin
            // another header line replaces the kept one
            cbuf_req.we    = 1'b1;
            cbuf_req.waddr = '0;
            cbuf_req.wdata = CHAR_GT;
            fill_d         = FILL_W'(1);
          end else begin
            // body starts: fetch comment byte 0, hold the first body byte.
            // No write happens while reading, so no forwarding is needed.
            tally_d        = '0;
            pend_base_d    = 1'b0;
            if (letter) begin
              if (max_bases_q != '0) begin
                tally_d     = TALLY_W'(1);
                pend_base_d = 1'b1;
              end else begin
                tally_d[CNT_W] = 1'b1;
              end
            end
            pend_byte_d    = c;
            emit_idx_d     = '0;
            cbuf_req.re    = 1'b1;
            cbuf_req.raddr = '0;
          end
        end
      end
      ST_BODY: begin
        if (take) begin
          if (eof || (c == CHAR_GT)) begin
            load        = 1'b1;
            out_kind_d  = KIND_END;
            out_value_d = '0;
            out_idx_d   = rec_cnt_q;
            out_len_d   = tally_q[CNT_W-1:0];
            out_trunc_d = tally_q[CNT_W];
            out_last_d  = 1'b1;
            if (!eof) begin
              rec_cnt_d      = rec_cnt_q + CNT_W'(1);
              cbuf_req.we    = 1'b1;
              cbuf_req.waddr = '0;
              cbuf_req.wdata = CHAR_GT;
              fill_d         = FILL_W'(1);
            end
          end else if (letter) begin
            if (keep) begin
              tally_d     = {tally_q[CNT_W], tally_inc};
              load        = 1'b1;
              out_kind_d  = KIND_BASE;
              out_value_d = c;
              out_idx_d   = rec_cnt_q;
              out_len_d   = tally_inc;
              out_trunc_d = tally_q[CNT_W];
              out_last_d  = 1'b1;
            end else begin
              tally_d[CNT_W] = 1'b1;
            end
          end
        end
      end
      ST_EMIT: begin
        // read data holds comment byte emit_idx_q
        if (load_ok) begin
          load        = 1'b1;
          out_kind_d  = KIND_COMMENT;
          out_value_d = cbuf_rdata;
          out_idx_d   = rec_cnt_q;
          out_len_d   = '0;
          out_trunc_d = 1'b0;
          out_last_d  = !more && !pend_base_q;
          if (more) begin
            emit_idx_d     = emit_idx_q + FILL_W'(1);
            cbuf_req.re    = 1'b1;
            cbuf_req.raddr = emit_idx_d[CADDR_W-1:0];
          end
        end
      end
      ST_BASE: begin
        if (load_ok) begin
          load        = 1'b1;
          out_kind_d  = KIND_BASE;
          out_value_d = pend_byte_q;
          out_idx_d   = rec_cnt_q;
          out_len_d   = CNT_W'(1);
          out_trunc_d = 1'b0;
          out_last_d  = 1'b1;
        end
      end
      default: ;
    endcase

    out_valid_d = load ? 1'b1 : (out_valid_q && !m_axis_tready_i);
  end

  fsp_comment_ram u_comment_ram (
    .clk_i   (clk_i),
    .req_i   (cbuf_req),
    .rdata_o (cbuf_rdata)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SEEK;
      fill_q      <= '0;
      tally_q     <= '0;
      rec_cnt_q   <= '0;
      max_bases_q <= MAX_BASES_RST;
      pend_base_q <= 1'b0;
      emit_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      tally_q     <= tally_d;
      rec_cnt_q   <= rec_cnt_d;
      pend_base_q <= pend_base_d;
      emit_idx_q  <= emit_idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) max_bases_q <= cfg_wdata_i;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pend_byte_q <= pend_byte_d;
    out_kind_q  <= out_kind_d;
    out_value_q <= out_value_d;
    out_idx_q   <= out_idx_d;
    out_len_q   <= out_len_d;
    out_trunc_q <= out_trunc_d;
    out_last_q  <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'b0, out_trunc_q, out_len_q, out_idx_q, out_value_q};
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

FILE: src/fsp_checker.sv
// ----------------------------------------------------------------------------
// fsp_checker
// Port-level checks of the FASTA record parser, bound to the top level.
// ----------------------------------------------------------------------------
module fsp_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               m_axis_tvalid_o,
  input logic                               m_axis_tready_i,
  input logic [fsp_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,
  input logic [1:0]                         m_axis_tuser_o,
  input logic                               m_axis_tlast_o
);
  import fsp_pkg::*;

  // stalled request holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output request changed while stalled");

  // record end carries no byte and closes its input's run
  a_end_fmt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == KIND_END) |->
      (m_axis_tdata_o[7:0] == '0) && m_axis_tlast_o)
    else $error("malformed record end");

  // comment bytes come before any base is counted
  a_comment_fmt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == KIND_COMMENT) |->
      (m_axis_tdata_o[56:32] == '0))
    else $error("comment byte with nonzero length");

  // a kept base always counts itself
  a_base_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == KIND_BASE) |->
      (m_axis_tdata_o[55:32] != '0))
    else $error("base with zero length");

endmodule

bind fasta_record_parser fsp_checker u_fsp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// FASTA record parser testbench
// Streams FASTA text through the parser, one byte per request, under random
// gaps on both stream sides, and checks every comment, base and record-end
// result against a cycle-free model of the parse. Runs a short directed file
// set first, then randomly built files under several max_bases settings.
// ----------------------------------------------------------------------------

module testbench;
  import fsp_pkg::*;

  // One expected output result
  typedef struct {
    result_kind_e      kind;
    logic [BYTE_W-1:0] value;
    logic [CNT_W-1:0]  rec_idx;
    logic [CNT_W-1:0]  length;
    logic              trunc;
    logic              last;
  } fasta_result_t;

  // Parse model plus result checking
  class fasta_record_checker;
    logic [CNT_W-1:0]  max_bases;
    parse_state_e      mode;
    logic [BYTE_W-1:0] comment_buf [COMMENT_LEN];
    int                comment_cnt;
    logic [CNT_W-1:0]  base_cnt;
    logic              trunc_mark;
    logic [CNT_W-1:0]  rec_count;
    fasta_result_t     pending_results[$];
    fasta_result_t     fresh[$];
    int                errors;
    int                bytes_taken;
    int                results_seen;
    int                records_closed;
    int                records_truncated;

    function new();
      max_bases         = MAX_BASES_RST;
      mode              = ST_SEEK;
      comment_cnt       = 0;
      base_cnt          = '0;
      trunc_mark        = 1'b0;
      rec_count         = '0;
      errors            = 0;
      bytes_taken       = 0;
      results_seen      = 0;
      records_closed    = 0;
      records_truncated = 0;
    endfunction

    function void emit(result_kind_e kind, logic [BYTE_W-1:0] value);
      fasta_result_t r;
      r.kind    = kind;
      r.value   = value;
      r.rec_idx = rec_count;
      r.length  = base_cnt;
      r.trunc   = trunc_mark;
      r.last    = 1'b0;
      fresh.push_back(r);
    endfunction

    // '>' always starts the comment buffer over
    function void open_header();
      comment_buf[0] = CHAR_GT;
      comment_cnt    = 1;
      mode           = ST_HEADER;
    endfunction

    function void close_record();
      emit(KIND_END, '0);
      records_closed++;
      if (trunc_mark) records_truncated++;
    endfunction

    // letters become bases up to max_bases, then only mark truncation
    function void take_base(logic [BYTE_W-1:0] c);
      if (!(c inside {[8'h41:8'h5A], [8'h61:8'h7A]})) return;
      if (base_cnt < max_bases) begin
        base_cnt++;
        emit(KIND_BASE, c);
      end else begin
        trunc_mark = 1'b1;
      end
    endfunction

    function void take_byte(logic [BYTE_W-1:0] c, logic eof);
      bytes_taken++;
      fresh.delete();
      case (mode)
        ST_SEEK: begin
          if (!eof && c == CHAR_GT) begin
            rec_count++;
            open_header();
          end
        end
        ST_HEADER: begin
          if (eof) begin
            mode = ST_SEEK;
          end else if (c == CHAR_LF) begin
            mode = ST_LINE_START;
          end else if (comment_cnt < COMMENT_LEN) begin
            comment_buf[comment_cnt] = c;
            comment_cnt++;
          end
        end
        ST_LINE_START: begin
          if (eof) begin
            mode = ST_SEEK;
          end else if (c == CHAR_GT) begin
            open_header();
          end else begin
            // body starts: flush the kept comment, then this byte
            base_cnt   = '0;
            trunc_mark = 1'b0;
            for (int i = 0; i < comment_cnt; i++) emit(KIND_COMMENT, comment_buf[i]);
            mode = ST_BODY;
            take_base(c);
          end
        end
        default: begin
          if (eof) begin
            close_record();
            mode = ST_SEEK;
          end else if (c == CHAR_GT) begin
            close_record();
            rec_count++;
            open_header();
          end else begin
            take_base(c);
          end
        end
      endcase
      if (fresh.size() > 0) fresh[fresh.size()-1].last = 1'b1;
      foreach (fresh[i]) pending_results.push_back(fresh[i]);
    endfunction

    function void mismatch(string field, longint unsigned want, longint unsigned got);
      $error("%s mismatch: expected %0h, actual %0h", field, want, got);
      errors++;
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data, logic [1:0] kind, logic last);
      fasta_result_t exp_r;
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d, data %h", kind, data);
        errors++;
        return;
      end
      exp_r = pending_results.pop_front();
      if (kind !== exp_r.kind)           mismatch("kind", exp_r.kind, kind);
      if (data[7:0] !== exp_r.value)     mismatch("value", exp_r.value, data[7:0]);
      if (data[31:8] !== exp_r.rec_idx)  mismatch("record_index", exp_r.rec_idx, data[31:8]);
      if (data[55:32] !== exp_r.length)  mismatch("length", exp_r.length, data[55:32]);
      if (data[56] !== exp_r.trunc)      mismatch("truncated", exp_r.trunc, data[56]);
      if (last !== exp_r.last)           mismatch("last_of_run", exp_r.last, last);
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CNT_W-1:0]      cfg_wdata_i;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [BYTE_W-1:0]     s_axis_tdata_i;  // [7:0] in_byte
  logic                  s_axis_tuser_i;  // [0] end_of_file
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  // [7:0] value, [31:8] record_index, [55:32] length, [56] truncated
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic [1:0]            m_axis_tuser_o;  // [1:0] kind
  logic                  m_axis_tlast_o;  // last_of_run

  fasta_record_checker sb;
  bit                  gaps_on = 1'b1;

  fasta_record_parser dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // 4 ns clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  // Receiver backpressure
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready_i = gaps_on ? ($urandom_range(0, 99) >= 37) : 1'b1;
    end
  end

  // Observe both handshakes; input first so its results queue in order
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) sb.take_byte(s_axis_tdata_i, s_axis_tuser_i);
      if (m_axis_tvalid_o && m_axis_tready_i)
        sb.check_result(m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
    end
  end

  // One input request, returns once it is taken
  task automatic send_item(input logic [BYTE_W-1:0] c, input logic eof);
    @(negedge clk_i);
    while (gaps_on && $urandom_range(0, 99) < 37) begin
      s_axis_tvalid_i = 1'b0;
      s_axis_tdata_i  = BYTE_W'($urandom_range(0, 255));
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = c;
    s_axis_tuser_i  = eof;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  // end of file carries a random, ignored byte
  task automatic send_eof();
    send_item(BYTE_W'($urandom_range(0, 255)), 1'b1);
  endtask

  // Wait for all results, then let the block settle
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic set_max_bases(input logic [CNT_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    sb.max_bases = v;
  endtask

  function automatic logic [BYTE_W-1:0] pick_byte(input logic [BYTE_W-1:0] avoid);
    logic [BYTE_W-1:0] c;
    c = BYTE_W'($urandom_range(0, 255));
    if (c == avoid) c ^= 8'h01;
    return c;
  endfunction

  // Random file: mostly well-formed records, some leading noise and
  // records cut short by end of file
  task automatic send_file(input int budget, input bit long_header);
    int                sent;
    int                len;
    int                nhdr;
    bit                dropped;
    logic [BYTE_W-1:0] c;
    sent = 0;
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 4)) send_item(BYTE_W'($urandom_range(0, 255)), 1'b0);
    while (sent < budget) begin
      dropped = 1'b0;
      nhdr    = ($urandom_range(0, 3) == 0) ? 2 : 1;
      for (int h = 0; h < nhdr && !dropped; h++) begin
        send_item(CHAR_GT, 1'b0);
        if (long_header) len = 40;
        else len = ($urandom_range(0, 4) == 0) ? $urandom_range(28, 45) : $urandom_range(0, 8);
        long_header = 1'b0;
        repeat (len) send_item(pick_byte(CHAR_LF), 1'b0);
        sent += len + 2;
        if ($urandom_range(0, 11) == 0) begin
          // cut inside the header line
          send_eof();
          dropped = 1'b1;
        end else begin
          send_item(CHAR_LF, 1'b0);
        end
      end
      if (!dropped && $urandom_range(0, 11) == 0) begin
        send_eof();
        dropped = 1'b1;
      end
      if (dropped) continue;
      // body lines; empty lines come up now and then
      repeat ($urandom_range(1, 3)) begin
        len = $urandom_range(0, 12);
        repeat (len) begin
          if ($urandom_range(0, 3) == 0) c = pick_byte(CHAR_GT);
          else c = BYTE_W'($urandom_range(0, 25)) + ($urandom_range(0, 1) ? 8'h61 : 8'h41);
          send_item(c, 1'b0);
        end
        send_item(CHAR_LF, 1'b0);
        sent += len + 1;
      end
    end
    send_eof();
  endtask

  // Main sequence
  initial begin
    sb = new();
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // junk before any header, end of file while seeking
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_eof();
    // header run keeps last line, non-letters skipped, '>' closes record,
    // end of file mid header drops it
    send_text(">x\n>hd\nAz9\n>q");
    send_eof();
    // complete header followed by end of file
    send_text(">r\n");
    send_eof();
    // empty first body line
    send_text(">\n\ng");
    send_eof();
    drain();

    // max_bases of 1: truncation
    set_max_bases(CNT_W'(1));
    send_text(">\nabc");
    send_eof();
    send_file(1, 1'b1);
    drain();

    // back-to-back stretch, no gaps on either side
    set_max_bases(CNT_W'(4));
    gaps_on = 1'b0;
    send_file(1, 1'b0);
    drain();
    gaps_on = 1'b1;

    set_max_bases(CNT_W'($urandom_range(2, 12)));
    send_file(1, 1'b0);
    drain();

    $display("run covered %0d input bytes under four max_bases settings, %0d results checked",
             sb.bytes_taken, sb.results_seen);
    $display("%0d records closed, %0d of them truncated",
             sb.records_closed, sb.records_truncated);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
